// File: hdl/gic_pkg.sv
// ----------------------------------------------------------------------------
// gic_pkg
// Shared types, constants and helpers of the gamepad input conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package gic_pkg;

    localparam int BUTTON_COUNT  = 14;
    localparam int FRACTION_BITS = 15;

    localparam logic [16:0] C_ONE     = 17'(1 << FRACTION_BITS);
    localparam logic [16:0] C_ONE_M1  = 17'((1 << FRACTION_BITS) - 1);

    // divider / root sizes
    localparam int DIV_NUM_W  = 48;
    localparam int DIV_DEN_W  = 33;
    localparam int DIV_QUOT_W = 17;
    localparam int SQ_W       = 32;
    localparam int ROOT_W     = 16;

    localparam int IN_W  = 104;
    localparam int OUT_W = 240;

    // register map
    typedef enum logic [2:0] {
        REG_DEADZONE  = 3'd0,
        REG_TH_LOW    = 3'd1,
        REG_TH_MIDDLE = 3'd2,
        REG_TH_HIGH   = 3'd3,
        REG_TRIG_FS   = 3'd4,
        REG_STICK_FS  = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_NONE    = 2'd0,
        PH_TRIGGER = 2'd1,
        PH_HOLD    = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        STR_ZERO   = 2'd0,
        STR_LOW    = 2'd1,
        STR_MIDDLE = 2'd2,
        STR_HIGH   = 2'd3
    } t_strength;

    typedef enum logic [4:0] {
        S_IDLE, S_TRIG_DIV, S_TRIG_WAIT, S_NORM_DIV, S_NORM_WAIT,
        S_MUL_XX, S_MUL_YY, S_LEN_SQRT, S_LEN_WAIT, S_MUL_DEN,
        S_MUL_AX, S_AX_DIV, S_AX_WAIT, S_OMUL_X, S_OMUL_Y,
        S_OSQRT, S_OSQRT_WAIT, S_DONE
    } t_state;

    // button slot -> mask bit
    localparam logic [3:0] C_MASK_BIT [16] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd12, 4'd13, 4'd14, 4'd15,
        4'd8, 4'd9, 4'd6, 4'd7, 4'd4, 4'd5, 4'd10, 4'd11
    };

    function automatic t_strength f_strength(input logic [15:0] v,
                                             input logic [14:0] th_l,
                                             input logic [14:0] th_m,
                                             input logic [14:0] th_h);
        t_strength s;
        if (v > {1'b0, th_h})      s = STR_HIGH;
        else if (v > {1'b0, th_m}) s = STR_MIDDLE;
        else if (v > {1'b0, th_l}) s = STR_LOW;
        else                       s = STR_ZERO;
        return s;
    endfunction

    function automatic t_phase f_next_phase(input t_phase p, input logic pressed);
        t_phase n;
        n = p;
        if (pressed) begin
            case (p)
                PH_NONE, PH_RELEASE: n = PH_TRIGGER;
                PH_TRIGGER:          n = PH_HOLD;
                default:             n = PH_HOLD;
            endcase
        end else begin
            case (p)
                PH_TRIGGER, PH_HOLD: n = PH_RELEASE;
                PH_RELEASE:          n = PH_NONE;
                default:             n = PH_NONE;
            endcase
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: hdl/gic_div.sv
// ----------------------------------------------------------------------------
// gic_div
// Restoring divider, one quotient bit per cycle, saturating quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module gic_div
    import gic_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire [DIV_NUM_W-1:0]     i_num,
    input  wire [DIV_DEN_W-1:0]     i_den,
    output logic                    o_done,
    output logic [DIV_QUOT_W-1:0]   o_quot
);

    localparam int DSH_W = DIV_DEN_W + DIV_QUOT_W;   // divisor shifted to top bit

    logic                   r_busy;
    logic                   r_done;
    logic [4:0]             r_cnt;
    logic [DIV_NUM_W-1:0]   r_rem;
    logic [DSH_W-1:0]       r_dsh;
    logic [DIV_QUOT_W-1:0]  r_quot;

    logic                   w_fit;
    logic                   w_ovf;

    assign w_ovf = ({2'b00, i_num} >= {i_den, 17'b0});
    assign w_fit = ({2'b00, r_rem} >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (w_ovf) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= 5'(DIV_QUOT_W - 1);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= {1'b0, i_den, 16'b0};
            r_quot <= w_ovf ? '1 : '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= DIV_NUM_W'({2'b00, r_rem} - r_dsh);
            end
            r_quot <= {r_quot[DIV_QUOT_W-2:0], w_fit};
            r_dsh  <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// File: hdl/gic_sqrt.sv
// ----------------------------------------------------------------------------
// gic_sqrt
// Floor integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gic_sqrt
    import gic_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire [SQ_W-1:0]      i_num,
    output logic                o_done,
    output logic [ROOT_W-1:0]   o_root
);

    logic            r_busy;
    logic            r_done;
    logic [SQ_W-1:0] r_n;
    logic [SQ_W-1:0] r_r;
    logic [SQ_W-1:0] r_bit;
    logic [SQ_W:0]   w_trial;

    assign w_trial = {1'b0, r_r} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_num;
            r_r   <= '0;
            r_bit <= SQ_W'(1) << (SQ_W - 2);
        end else if (r_busy) begin
            if ({1'b0, r_n} >= w_trial) begin
                r_n <= SQ_W'({1'b0, r_n} - w_trial);
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[ROOT_W-1:0];

endmodule

`default_nettype wire

// File: hdl/gamepad_input_conditioner.sv
// ----------------------------------------------------------------------------
// gamepad_input_conditioner
// Per-frame gamepad conditioning: button edges, triggers, radial deadzone.
// ----------------------------------------------------------------------------
// Sequence for a connected frame: 2 trigger divisions, then per stick 4 divisions,
//   2 roots and 7 multiplies; shorter when a division saturates or a stick sits in
//   the deadzone. A link-down frame goes straight to the result stage.
// Flow: one request at a time, s_axis_tready high only when idle; the next request
//   is taken only once the last result has been loaded into the output register.
// Reset (synchronous, active low): config to defaults, history cleared, no output.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_input_conditioner
    import gic_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    // fields from bit 0: pad_connected(1), button_bits(16), left_trigger_raw(8),
    // right_trigger_raw(8), left_x_raw, left_y_raw, right_x_raw, right_y_raw (16)
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire [IN_W-1:0]   s_axis_tdata,
    // fields from bit 0: link_up(1), button_states(28), left_trigger_level(15),
    // right_trigger_level(15), trigger_deltas(34), left_stick_xy(32),
    // right_stick_xy(32), left_stick_delta(34), right_stick_delta(34),
    // strengths(8), zero pad(7)
    output logic             m_axis_tvalid,
    input  wire              m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,
    // config write channel
    input  wire              i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire [2:0]        i_cfg_index,
    input  wire [15:0]       i_cfg_data
);

    // ---------------- configuration registers ----------------
    logic [14:0] r_dz, r_th_l, r_th_m, r_th_h;
    logic [7:0]  r_trig_fs;
    logic [15:0] r_stick_fs;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz       <= 15'd6554;
            r_th_l     <= 15'd8192;
            r_th_m     <= 15'd16384;
            r_th_h     <= 15'd24576;
            r_trig_fs  <= 8'd255;
            r_stick_fs <= 16'd32767;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_DEADZONE:  r_dz       <= i_cfg_data[14:0];
                REG_TH_LOW:    r_th_l     <= i_cfg_data[14:0];
                REG_TH_MIDDLE: r_th_m     <= i_cfg_data[14:0];
                REG_TH_HIGH:   r_th_h     <= i_cfg_data[14:0];
                REG_TRIG_FS:   r_trig_fs  <= i_cfg_data[7:0];
                REG_STICK_FS:  r_stick_fs <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // full scale of zero behaves as one
    logic [7:0]  w_trig_fs;
    logic [15:0] w_stick_fs;
    assign w_trig_fs  = (r_trig_fs == 8'd0) ? 8'd1 : r_trig_fs;
    assign w_stick_fs = (r_stick_fs == 16'd0) ? 16'd1 : r_stick_fs;

    // ---------------- sequencer ----------------
    t_state r_state, n_state;

    logic w_accept;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // shared units
    logic                   w_div_start;
    logic [DIV_NUM_W-1:0]   w_div_num;
    logic [DIV_DEN_W-1:0]   w_div_den;
    logic                   w_div_done;
    logic [DIV_QUOT_W-1:0]  w_div_quot;

    logic                   w_sq_start;
    logic [SQ_W-1:0]        w_sq_num;
    logic                   w_sq_done;
    logic [ROOT_W-1:0]      w_sq_root;

    logic                   w_mul_en;
    logic [16:0]            w_mul_a, w_mul_b;

    // frame and history
    logic [7:0]         r_trig_raw [2];
    logic [15:0]        r_stick_raw [4];
    logic [1:0]         r_phase [BUTTON_COUNT];
    logic [14:0]        r_tprev [2];
    logic [15:0]        r_sprev [4];
    logic               r_idx;      // trigger or stick select
    logic               r_ax;       // axis select

    // working registers
    logic [15:0] r_xm, r_ym;
    logic        r_xneg, r_yneg;
    logic [15:0] r_len;
    logic [31:0] r_den;
    logic [15:0] r_ox, r_oy;
    logic [31:0] r_acc;
    logic [33:0] r_prod;

    // result staging
    logic        r_res_link;
    logic [27:0] r_res_bs;
    logic [14:0] r_res_lvl [2];
    logic [33:0] r_res_td;
    logic [31:0] r_res_xy [2];
    logic [33:0] r_res_dl [2];
    logic [7:0]  r_res_str;

    logic               r_m_valid;
    logic [OUT_W-1:0]   r_m_data;

    // current stick axis magnitude
    logic [15:0] w_raw;
    logic [16:0] w_raw_ext;
    logic [16:0] w_raw_mag;
    assign w_raw     = r_stick_raw[{r_idx, r_ax}];
    assign w_raw_ext = {w_raw[15], w_raw};
    assign w_raw_mag = w_raw[15] ? 17'(-w_raw_ext) : w_raw_ext;

    // clamped quotient (magnitude up to 1.0)
    logic [15:0] w_qc;
    assign w_qc = (w_div_quot > C_ONE) ? C_ONE[15:0] : w_div_quot[15:0];

    // trigger level after deadzone and saturation
    logic [14:0] w_tlvl;
    assign w_tlvl = (w_qc < {1'b0, r_dz}) ? 15'd0 :
                    (w_qc > C_ONE_M1[15:0]) ? C_ONE_M1[14:0] : w_qc[14:0];

    // rescaled axis with sign-dependent saturation
    logic        w_axneg;
    logic [15:0] w_axout;
    assign w_axneg = r_ax ? r_yneg : r_xneg;
    always_comb begin
        if (w_axneg) begin
            w_axout = 16'(17'd0 - {1'b0, w_qc});
        end else if (w_div_quot > C_ONE_M1) begin
            w_axout = C_ONE_M1[15:0];
        end else begin
            w_axout = w_div_quot[15:0];
        end
    end

    // output magnitudes
    logic [16:0] w_ox_ext, w_oy_ext, w_ox_mag, w_oy_mag;
    assign w_ox_ext = {r_ox[15], r_ox};
    assign w_oy_ext = {r_oy[15], r_oy};
    assign w_ox_mag = r_ox[15] ? 17'(-w_ox_ext) : w_ox_ext;
    assign w_oy_mag = r_oy[15] ? 17'(-w_oy_ext) : w_oy_ext;

    logic [15:0] w_len_dz;
    logic [15:0] w_one_dz;
    assign w_len_dz = r_len - {1'b0, r_dz};
    assign w_one_dz = 16'(C_ONE - {2'b00, r_dz});

    logic [15:0] w_sp_x, w_sp_y;
    assign w_sp_x = r_sprev[{r_idx, 1'b0}];
    assign w_sp_y = r_sprev[{r_idx, 1'b1}];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        w_sq_start  = 1'b0;
        w_sq_num    = '0;
        w_mul_en    = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = s_axis_tdata[0] ? S_TRIG_DIV : S_DONE;
            end
            S_TRIG_DIV: begin
                w_div_start = 1'b1;
                w_div_num   = DIV_NUM_W'({r_trig_raw[r_idx], 16'b0}) +
                              DIV_NUM_W'(w_trig_fs);
                w_div_den   = DIV_DEN_W'({w_trig_fs, 1'b0});
                n_state     = S_TRIG_WAIT;
            end
            S_TRIG_WAIT: begin
                if (w_div_done) n_state = r_idx ? S_NORM_DIV : S_TRIG_DIV;
            end
            S_NORM_DIV: begin
                w_div_start = 1'b1;
                w_div_num   = DIV_NUM_W'({w_raw_mag, 16'b0}) + DIV_NUM_W'(w_stick_fs);
                w_div_den   = DIV_DEN_W'({w_stick_fs, 1'b0});
                n_state     = S_NORM_WAIT;
            end
            S_NORM_WAIT: begin
                if (w_div_done) n_state = r_ax ? S_MUL_XX : S_NORM_DIV;
            end
            S_MUL_XX: begin
                w_mul_en = 1'b1;
                w_mul_a  = {1'b0, r_xm};
                w_mul_b  = {1'b0, r_xm};
                n_state  = S_MUL_YY;
            end
            S_MUL_YY: begin
                w_mul_en = 1'b1;
                w_mul_a  = {1'b0, r_ym};
                w_mul_b  = {1'b0, r_ym};
                n_state  = S_LEN_SQRT;
            end
            S_LEN_SQRT: begin
                w_sq_start = 1'b1;
                w_sq_num   = r_acc + r_prod[31:0];
                n_state    = S_LEN_WAIT;
            end
            S_LEN_WAIT: begin
                if (w_sq_done) begin
                    if (w_sq_root == '0 || w_sq_root < {1'b0, r_dz}) n_state = S_OMUL_X;
                    else                                              n_state = S_MUL_DEN;
                end
            end
            S_MUL_DEN: begin
                // denominator: length * (1.0 - deadzone)
                w_mul_en = 1'b1;
                w_mul_a  = {1'b0, r_len};
                w_mul_b  = {1'b0, w_one_dz};
                n_state  = S_MUL_AX;
            end
            S_MUL_AX: begin
                w_mul_en = 1'b1;
                w_mul_a  = {1'b0, r_ax ? r_ym : r_xm};
                w_mul_b  = {1'b0, w_len_dz};
                n_state  = S_AX_DIV;
            end
            S_AX_DIV: begin
                w_div_start = 1'b1;
                w_div_num   = DIV_NUM_W'({r_prod[31:0], 16'b0}) + DIV_NUM_W'(r_den);
                w_div_den   = DIV_DEN_W'({r_den, 1'b0});
                n_state     = S_AX_WAIT;
            end
            S_AX_WAIT: begin
                if (w_div_done) n_state = r_ax ? S_OMUL_X : S_MUL_AX;
            end
            S_OMUL_X: begin
                w_mul_en = 1'b1;
                w_mul_a  = w_ox_mag;
                w_mul_b  = w_ox_mag;
                n_state  = S_OMUL_Y;
            end
            S_OMUL_Y: begin
                w_mul_en = 1'b1;
                w_mul_a  = w_oy_mag;
                w_mul_b  = w_oy_mag;
                n_state  = S_OSQRT;
            end
            S_OSQRT: begin
                w_sq_start = 1'b1;
                w_sq_num   = r_acc + r_prod[31:0];
                n_state    = S_OSQRT_WAIT;
            end
            S_OSQRT_WAIT: begin
                if (w_sq_done) n_state = r_idx ? S_DONE : S_NORM_DIV;
            end
            S_DONE: begin
                if (!r_m_valid || m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // shared multiplier, registered
    always_ff @(posedge i_clk) begin
        if (w_mul_en) r_prod <= w_mul_a * w_mul_b;
    end

    // ---------------- datapath and history ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUTTON_COUNT; i++) r_phase[i] <= PH_NONE;
            for (int i = 0; i < 2; i++) r_tprev[i] <= '0;
            for (int i = 0; i < 4; i++) r_sprev[i] <= '0;
            r_idx <= 1'b0;
            r_ax  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_idx <= 1'b0;
                        r_ax  <= 1'b0;
                        if (!s_axis_tdata[0]) begin
                            // link down: drop all history
                            for (int i = 0; i < BUTTON_COUNT; i++) r_phase[i] <= PH_NONE;
                            for (int i = 0; i < 2; i++) r_tprev[i] <= '0;
                            for (int i = 0; i < 4; i++) r_sprev[i] <= '0;
                        end else begin
                            for (int i = 0; i < BUTTON_COUNT; i++) begin
                                r_phase[i] <= f_next_phase(t_phase'(r_phase[i]),
                                              s_axis_tdata[1 + int'(C_MASK_BIT[i])]);
                            end
                        end
                    end
                end
                S_TRIG_WAIT: begin
                    if (w_div_done) begin
                        r_tprev[r_idx] <= w_tlvl;
                        r_idx          <= ~r_idx;
                    end
                end
                S_NORM_WAIT: begin
                    if (w_div_done) r_ax <= ~r_ax;
                end
                S_LEN_WAIT: begin
                    if (w_sq_done) r_ax <= 1'b0;
                end
                S_AX_WAIT: begin
                    if (w_div_done) r_ax <= ~r_ax;
                end
                S_OSQRT_WAIT: begin
                    if (w_sq_done) begin
                        r_sprev[{r_idx, 1'b0}] <= r_ox;
                        r_sprev[{r_idx, 1'b1}] <= r_oy;
                        r_idx                  <= ~r_idx;
                        r_ax                   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // working and result registers (no reset needed)
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_trig_raw[0]  <= s_axis_tdata[24:17];
                    r_trig_raw[1]  <= s_axis_tdata[32:25];
                    r_stick_raw[0] <= s_axis_tdata[48:33];
                    r_stick_raw[1] <= s_axis_tdata[64:49];
                    r_stick_raw[2] <= s_axis_tdata[80:65];
                    r_stick_raw[3] <= s_axis_tdata[96:81];
                    r_res_link     <= s_axis_tdata[0];
                    r_res_lvl[0]   <= '0;
                    r_res_lvl[1]   <= '0;
                    r_res_td       <= '0;
                    r_res_xy[0]    <= '0;
                    r_res_xy[1]    <= '0;
                    r_res_dl[0]    <= '0;
                    r_res_dl[1]    <= '0;
                    r_res_str      <= '0;
                    for (int i = 0; i < BUTTON_COUNT; i++) begin
                        r_res_bs[2*i +: 2] <= s_axis_tdata[0] ?
                            2'(f_next_phase(t_phase'(r_phase[i]),
                                            s_axis_tdata[1 + int'(C_MASK_BIT[i])])) :
                            2'(PH_NONE);
                    end
                end
            end
            S_TRIG_WAIT: begin
                if (w_div_done) begin
                    r_res_lvl[r_idx]          <= w_tlvl;
                    r_res_td[17*r_idx +: 17]  <= {2'b00, w_tlvl} - {2'b00, r_tprev[r_idx]};
                    r_res_str[2*r_idx +: 2]   <= 2'(f_strength({1'b0, w_tlvl},
                                                    r_th_l, r_th_m, r_th_h));
                end
            end
            S_NORM_WAIT: begin
                if (w_div_done) begin
                    if (r_ax) begin
                        r_ym   <= w_qc;
                        r_yneg <= w_raw[15];
                    end else begin
                        r_xm   <= w_qc;
                        r_xneg <= w_raw[15];
                    end
                end
            end
            S_MUL_YY:  r_acc <= r_prod[31:0];
            S_LEN_WAIT: begin
                if (w_sq_done) begin
                    r_len <= w_sq_root;
                    r_ox  <= '0;
                    r_oy  <= '0;
                end
            end
            S_MUL_AX: begin
                if (!r_ax) r_den <= r_prod[31:0];
            end
            S_AX_WAIT: begin
                if (w_div_done) begin
                    if (r_ax) r_oy <= w_axout;
                    else      r_ox <= w_axout;
                end
            end
            S_OMUL_Y:  r_acc <= r_prod[31:0];
            S_OSQRT_WAIT: begin
                if (w_sq_done) begin
                    r_res_xy[r_idx]            <= {r_oy, r_ox};
                    r_res_dl[r_idx]            <= {w_oy_ext - {w_sp_y[15], w_sp_y},
                                                   w_ox_ext - {w_sp_x[15], w_sp_x}};
                    r_res_str[4+2*r_idx +: 2]  <= 2'(f_strength(w_sq_root,
                                                     r_th_l, r_th_m, r_th_h));
                end
            end
            default: ;
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == S_DONE && (!r_m_valid || m_axis_tready)) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_m_valid || m_axis_tready)) begin
            r_m_data <= {7'b0, r_res_str, r_res_dl[1], r_res_dl[0], r_res_xy[1],
                         r_res_xy[0], r_res_td, r_res_lvl[1], r_res_lvl[0],
                         r_res_bs, r_res_link};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // ---------------- shared units ----------------
    gic_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    gic_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_num   (w_sq_num),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

endmodule

`default_nettype wire

// File: tb/gic_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_checker
// Watches the input, output and config channels of the gamepad conditioner,
// predicts each frame result and compares it field by field.
// ----------------------------------------------------------------------------

module gic_checker
    import gic_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire              i_in_ready,
    input  wire [IN_W-1:0]   i_in_data,
    input  wire              i_out_valid,
    input  wire              i_out_ready,
    input  wire [OUT_W-1:0]  i_out_data,
    input  wire              i_cfg_valid,
    input  wire              i_cfg_ready,
    input  wire [2:0]        i_cfg_index,
    input  wire [15:0]       i_cfg_data,
    output int               o_errors,
    output int               o_pending
);

    localparam longint ONE = longint'(1) << FRACTION_BITS;

    // shadow config
    longint dz_reg, th_lo, th_mid, th_hi, trig_fs, stick_fs;
    // shadow history
    t_phase  phase_q [BUTTON_COUNT];
    longint  trig_prev [2];
    longint  stick_prev [4];

    logic [OUT_W-1:0] frame_results [$];

    // floor square root, two bits per step
    function automatic longint isqrt(longint n);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint round_div(longint num, longint den);
        return (num * 2 + den) / (den * 2);
    endfunction

    function automatic longint scale_to_q(longint raw, longint fs);
        longint mag, q;
        mag = raw < 0 ? -raw : raw;
        q = round_div(mag * ONE, fs == 0 ? 1 : fs);
        if (q > ONE) q = ONE;
        return raw < 0 ? -q : q;
    endfunction

    function automatic logic [1:0] grade(longint v);
        if (v > th_hi) return STR_HIGH;
        if (v > th_mid) return STR_MIDDLE;
        if (v > th_lo) return STR_LOW;
        return STR_ZERO;
    endfunction

    function automatic longint stretch_axis(longint c, longint len, longint dz);
        longint mag, q;
        mag = c < 0 ? -c : c;
        q = round_div(mag * (len - dz) * ONE, len * (ONE - dz));
        if (c < 0) begin
            if (q > ONE) q = ONE;
            return -q;
        end
        if (q > ONE - 1) q = ONE - 1;
        return q;
    endfunction

    task automatic clear_history();
        for (int i = 0; i < BUTTON_COUNT; i++) phase_q[i] = PH_NONE;
        trig_prev = '{0, 0};
        stick_prev = '{0, 0, 0, 0};
    endtask

    // one stick: writes packed xy and delta, returns strength
    task automatic shape_stick(input int s, input longint rx, input longint ry,
                               output logic [31:0] xy, output logic [33:0] dl,
                               output logic [1:0] st);
        longint x, y, dz, len, ox, oy, dx, dy;
        x = scale_to_q(rx, stick_fs);
        y = scale_to_q(ry, stick_fs);
        dz = dz_reg >= ONE ? ONE - 1 : dz_reg;
        len = isqrt(x * x + y * y);
        ox = 0;
        oy = 0;
        if (len != 0 && len >= dz) begin
            ox = stretch_axis(x, len, dz);
            oy = stretch_axis(y, len, dz);
        end
        dx = ox - stick_prev[2*s];
        dy = oy - stick_prev[2*s+1];
        stick_prev[2*s] = ox;
        stick_prev[2*s+1] = oy;
        xy = {16'(oy), 16'(ox)};
        dl = {17'(dy), 17'(dx)};
        st = grade(isqrt(ox * ox + oy * oy));
    endtask

    task automatic condition_frame(input logic [IN_W-1:0] f);
        logic [OUT_W-1:0] r;
        logic [27:0] bst;
        logic [14:0] lvl [2];
        logic [33:0] tdel, ldl, rdl;
        logic [31:0] lxy, rxy;
        logic [7:0]  str;
        logic [1:0]  st;
        logic [15:0] btn;
        longint v;
        r = '0;
        if (!f[0]) begin
            clear_history();
            frame_results.push_back(r);
            return;
        end
        btn = f[16:1];
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            phase_q[i] = f_next_phase(phase_q[i], btn[C_MASK_BIT[i]]);
            bst[2*i +: 2] = phase_q[i];
        end
        for (int i = 0; i < 2; i++) begin
            v = scale_to_q(longint'(f[17 + 8*i +: 8]), trig_fs);
            if (v < dz_reg) v = 0;
            if (v > ONE - 1) v = ONE - 1;
            tdel[17*i +: 17] = 17'(v - trig_prev[i]);
            trig_prev[i] = v;
            lvl[i] = 15'(v);
            str[2*i +: 2] = grade(v);
        end
        shape_stick(0, longint'($signed(f[33 +: 16])), longint'($signed(f[49 +: 16])),
                    lxy, ldl, st);
        str[5:4] = st;
        shape_stick(1, longint'($signed(f[65 +: 16])), longint'($signed(f[81 +: 16])),
                    rxy, rdl, st);
        str[7:6] = st;
        r = {7'd0, str, rdl, ldl, rxy, lxy, tdel, lvl[1], lvl[0], bst, 1'b1};
        frame_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s got %h want %h", $realtime, what, got, want);
        o_errors++;
    endtask

    task automatic compare_result(input logic [OUT_W-1:0] got);
        logic [OUT_W-1:0] w;
        if (frame_results.size() == 0) begin
            report_mismatch("unexpected result", got[63:0], 0);
            return;
        end
        w = frame_results.pop_front();
        if (got[0] !== w[0]) report_mismatch("link_up", got[0], w[0]);
        if (got[28:1] !== w[28:1]) report_mismatch("button_states", got[28:1], w[28:1]);
        if (got[43:29] !== w[43:29]) report_mismatch("lt_level", got[43:29], w[43:29]);
        if (got[58:44] !== w[58:44]) report_mismatch("rt_level", got[58:44], w[58:44]);
        if (got[92:59] !== w[92:59]) report_mismatch("trig_delta", got[92:59], w[92:59]);
        if (got[124:93] !== w[124:93]) report_mismatch("left_xy", got[124:93], w[124:93]);
        if (got[156:125] !== w[156:125])
            report_mismatch("right_xy", got[156:125], w[156:125]);
        if (got[190:157] !== w[190:157])
            report_mismatch("left_delta", got[190:157], w[190:157]);
        if (got[224:191] !== w[224:191])
            report_mismatch("right_delta", got[224:191], w[224:191]);
        if (got[232:225] !== w[232:225])
            report_mismatch("strengths", got[232:225], w[232:225]);
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dz_reg   = 6554;
            th_lo    = 8192;
            th_mid   = 16384;
            th_hi    = 24576;
            trig_fs  = 255;
            stick_fs = 32767;
            clear_history();
            frame_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) compare_result(i_out_data);
            if (i_in_valid && i_in_ready) condition_frame(i_in_data);
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_DEADZONE:  dz_reg   = i_cfg_data[14:0];
                    REG_TH_LOW:    th_lo    = i_cfg_data[14:0];
                    REG_TH_MIDDLE: th_mid   = i_cfg_data[14:0];
                    REG_TH_HIGH:   th_hi    = i_cfg_data[14:0];
                    REG_TRIG_FS:   trig_fs  = i_cfg_data[7:0];
                    REG_STICK_FS:  stick_fs = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = frame_results.size();
    end

endmodule

// File: tb/gamepad_input_conditioner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_input_conditioner_tb
// Drives poll frames and config writes into the conditioner under varying
// back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------

module gamepad_input_conditioner_tb;
    import gic_pkg::*;

    localparam int LIMIT = 3_000_000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_valid = 1'b0;
    wire               s_ready;
    logic [IN_W-1:0]   s_data = '0;
    wire               m_valid;
    logic              m_ready = 1'b0;
    wire [OUT_W-1:0]   m_data;
    logic              cfg_valid = 1'b0;
    wire               cfg_ready;
    logic [2:0]        cfg_index = '0;
    logic [15:0]       cfg_data = '0;

    int errors, pending;
    int send_idle_pct = 0;   // chance the sender idles per cycle
    int recv_stall_pct = 0;  // chance the receiver stalls per cycle
    bit hold_off = 1'b0;     // long receiver hold-off in progress
    int cycles = 0;

    always #5 i_clk = ~i_clk;

    gamepad_input_conditioner dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    gic_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data),
        .i_out_valid(m_valid), .i_out_ready(m_ready), .i_out_data(m_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: random stalls, or a full hold-off
    always @(posedge i_clk)
        m_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // frame request; idles first at the current rate, valid stays up after
    // the accept so that back-to-back requests need no gap
    task automatic send_frame(input logic [IN_W-1:0] f);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= f;
        do @(posedge i_clk); while (!s_ready);
    endtask

    // quiesce: drop valid, drain results, then cover the block's latency
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(4000)) - 16'd2000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rand_frame();
        logic [15:0] btn;
        btn = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom) & 16'($urandom);
        return {pick_axis(), pick_axis(), pick_axis(), pick_axis(),
                8'($urandom), 8'($urandom), btn, 1'($urandom_range(19) != 0)};
    endfunction

    function automatic logic [IN_W-1:0] make_frame(input logic c, input logic [15:0] b,
                                                   input logic [7:0] lt, rt,
                                                   input logic [15:0] lx, ly, rx, ry);
        return {ry, rx, ly, lx, rt, lt, b, c};
    endfunction

    task automatic random_phase(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) send_frame(rand_frame());
        s_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: button edges, extremes, link drop, zero vector
        send_frame(make_frame(1, 16'hFFFF, 8'hFF, 8'h00, 16'h7FFF, 16'h8000, 0, 0));
        send_frame(make_frame(1, 16'hFFFF, 8'h00, 8'hFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
        send_frame(make_frame(1, 16'h0000, 8'h19, 8'h1A, 16'd100, 16'hFF9C, 16'd0, 16'd7000));
        send_frame(make_frame(1, 16'h5555, 8'h80, 8'h40, 16'd6554, 0, 0, 16'hE666));
        send_frame(make_frame(1, 16'hAAAA, 8'hC0, 8'hFE, 16'h4000, 16'h4000, 16'hC000, 16'h4000));
        send_frame(make_frame(0, 16'hFFFF, 8'hFF, 8'hFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_frame(make_frame(1, 16'h0001, 8'h01, 8'h01, 16'h0001, 16'hFFFF, 0, 0));
        send_frame(make_frame(1, 16'h0000, 8'h00, 8'h00, 0, 0, 16'h8000, 16'h7FFF));
        drain();

        // extremes of config
        write_reg(REG_DEADZONE, 16'd0);
        write_reg(REG_TH_LOW, 16'd0);
        write_reg(REG_TH_MIDDLE, 16'd0);
        write_reg(REG_TH_HIGH, 16'd0);
        write_reg(REG_TRIG_FS, 16'd1);
        write_reg(REG_STICK_FS, 16'd32768);
        random_phase(150, 0, 0);
        drain();

        write_reg(REG_DEADZONE, 16'd32767);
        write_reg(REG_TH_LOW, 16'd32767);
        write_reg(REG_TH_MIDDLE, 16'd32767);
        write_reg(REG_TH_HIGH, 16'd32767);
        write_reg(REG_TRIG_FS, 16'd0);     // acts as one
        write_reg(REG_STICK_FS, 16'd0);
        random_phase(100, 59, 0);
        drain();

        write_reg(REG_DEADZONE, 16'd6554);
        write_reg(REG_TH_LOW, 16'd8192);
        write_reg(REG_TH_MIDDLE, 16'd16384);
        write_reg(REG_TH_HIGH, 16'd24576);
        write_reg(REG_TRIG_FS, 16'd255);
        write_reg(REG_STICK_FS, 16'd32767);
        random_phase(200, 0, 59);

        // long hold-off: sender keeps offering while output is blocked
        fork
            begin
                hold_off = 1'b1;
                repeat (2000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_phase(10, 0, 0);
        join
        drain();

        write_reg(REG_DEADZONE, 16'($urandom_range(12000)));
        write_reg(REG_TH_LOW, 16'($urandom_range(10000)));
        write_reg(REG_TH_MIDDLE, 16'($urandom_range(20000)));
        write_reg(REG_TH_HIGH, 16'($urandom_range(32767)));
        write_reg(REG_TRIG_FS, 16'($urandom_range(255, 1)));
        write_reg(REG_STICK_FS, 16'($urandom_range(32768, 1)));
        random_phase(200, 32, 32);
        drain();

        write_reg(REG_STICK_FS, 16'd1000);
        write_reg(REG_TRIG_FS, 16'd100);
        random_phase(280, 0, 0);

        drain();
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule
